>>> rtl/core/npem_pkg.sv
package npem_pkg;

  // item codes
  localparam logic [1:0] KIND_FIND  = 2'd0;
  localparam logic [1:0] KIND_MARK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // palette layout
  localparam logic [7:0] FIRST_ENTRY = 8'd16;
  localparam logic [7:0] GREY_START  = 8'd232;
  localparam logic [7:0] LAST_ENTRY  = 8'd255;
  localparam logic [7:0] GREY_BASE   = 8'd8;
  localparam logic [7:0] GREY_STEP   = 8'd10;
  localparam logic [2:0] LEVEL_LAST  = 3'd5;

  localparam int unsigned ENTRY_COUNT = 256;
  localparam int unsigned DIST_W      = 18;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] color;
    logic [7:0]  entry_to_exclude;
  } item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] nearest_entry;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic init;
    logic step;
    logic mark;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic pipe_busy;
  } status_t;

  // channel value of a cube level index
  function automatic logic [7:0] cube_level(logic [2:0] idx);
    logic [7:0] lvl;
    unique case (idx)
      3'd0:    lvl = 8'd0;
      3'd1:    lvl = 8'd95;
      3'd2:    lvl = 8'd135;
      3'd3:    lvl = 8'd175;
      3'd4:    lvl = 8'd215;
      3'd5:    lvl = 8'd255;
      default: lvl = 8'd0;
    endcase
    return lvl;
  endfunction

endpackage

>>> rtl/core/nearest_palette_entry_match.sv
// Finds the nearest palette entry (16 to 255, 6x6x6 cube plus grey ramp) to a
// 24-bit rgb color by squared distance, skipping entries marked excluded; the
// lowest entry wins a tie. An item is taken when start is high and busy is low.
// Mark and clear items finish at the edge that takes them and give no result,
// so busy stays low. A find item walks the 240 candidates one per cycle through
// a three-stage distance pipeline: done_o pulses for one cycle once the pipeline
// has drained, with the answer on result_o, and busy is low again in that cycle.
// The receiver cannot stall the result, so it must take it in that cycle.
module nearest_palette_entry_match (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  npem_pkg::item_t   item_i,
  output logic              done_o,
  output npem_pkg::result_t result_o
);
  import npem_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  npem_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .kind_i   (item_i.kind),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // exclusion store and distance pipeline
  npem_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

>>> rtl/core/npem_datapath.sv
module npem_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  npem_pkg::cmd_t    cmd_i,
  input  npem_pkg::item_t   item_i,
  output npem_pkg::status_t status_o,
  output npem_pkg::result_t result_o
);
  import npem_pkg::*;

  // exclusion store: memory plus valid bits cleared at once
  logic                   excl_mem_q [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] excl_vld_q;

  // scan position
  logic [7:0] entry_q;
  logic [2:0] lvl_r_q, lvl_g_q, lvl_b_q;
  logic [7:0] grey_q;
  logic [7:0] tgt_r_q, tgt_g_q, tgt_b_q;

  // pipeline stages
  logic       s1_vld_q, s2_vld_q;
  logic [7:0] s1_dr_q, s1_dg_q, s1_db_q;
  logic [7:0] s1_entry_q;
  logic       s1_mem_q, s1_vbit_q;
  logic [15:0] s2_sr_q, s2_sg_q, s2_sb_q;
  logic [7:0]  s2_entry_q;
  logic        s2_excl_q;

  // running best
  logic              found_q;
  logic [7:0]        best_entry_q;
  logic [DIST_W-1:0] best_dist_q;

  logic              in_grey;
  logic [7:0]        ch_r, ch_g, ch_b;
  logic [7:0]        d_r, d_g, d_b;
  logic [DIST_W-1:0] cand_dist;
  logic              take;

  // channels of the entry at the scan position
  always_comb begin
    in_grey = (entry_q >= GREY_START);
    ch_r    = in_grey ? grey_q : cube_level(lvl_r_q);
    ch_g    = in_grey ? grey_q : cube_level(lvl_g_q);
    ch_b    = in_grey ? grey_q : cube_level(lvl_b_q);
    d_r     = (tgt_r_q >= ch_r) ? (tgt_r_q - ch_r) : (ch_r - tgt_r_q);
    d_g     = (tgt_g_q >= ch_g) ? (tgt_g_q - ch_g) : (ch_g - tgt_g_q);
    d_b     = (tgt_b_q >= ch_b) ? (tgt_b_q - ch_b) : (ch_b - tgt_b_q);
  end

  // distance and best update
  always_comb begin
    cand_dist = {2'b00, s2_sr_q} + {2'b00, s2_sg_q} + {2'b00, s2_sb_q};
    take      = s2_vld_q && !s2_excl_q && (!found_q || (cand_dist < best_dist_q));
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark) begin
      excl_mem_q[item_i.entry_to_exclude] <= 1'b1;
    end
    if (cmd_i.step) begin
      s1_mem_q  <= excl_mem_q[entry_q];
      s1_vbit_q <= excl_vld_q[entry_q];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      excl_vld_q <= '0;
      entry_q    <= FIRST_ENTRY;
      lvl_r_q    <= '0;
      lvl_g_q    <= '0;
      lvl_b_q    <= '0;
      grey_q     <= GREY_BASE;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        excl_vld_q <= '0;
      end else if (cmd_i.mark) begin
        excl_vld_q[item_i.entry_to_exclude] <= 1'b1;
      end

      s1_vld_q <= cmd_i.step;
      s2_vld_q <= s1_vld_q;

      if (cmd_i.init) begin
        entry_q <= FIRST_ENTRY;
        lvl_r_q <= '0;
        lvl_g_q <= '0;
        lvl_b_q <= '0;
        grey_q  <= GREY_BASE;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.step) begin
          entry_q <= entry_q + 8'd1;
          if (in_grey) begin
            grey_q <= grey_q + GREY_STEP;
          end else if (lvl_b_q != LEVEL_LAST) begin
            lvl_b_q <= lvl_b_q + 3'd1;
          end else begin
            lvl_b_q <= '0;
            if (lvl_g_q != LEVEL_LAST) begin
              lvl_g_q <= lvl_g_q + 3'd1;
            end else begin
              lvl_g_q <= '0;
              lvl_r_q <= (lvl_r_q != LEVEL_LAST) ? lvl_r_q + 3'd1 : 3'd0;
            end
          end
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      tgt_r_q <= item_i.color[23:16];
      tgt_g_q <= item_i.color[15:8];
      tgt_b_q <= item_i.color[7:0];
    end
    s1_dr_q    <= d_r;
    s1_dg_q    <= d_g;
    s1_db_q    <= d_b;
    s1_entry_q <= entry_q;
    s2_sr_q    <= 16'(s1_dr_q) * 16'(s1_dr_q);
    s2_sg_q    <= 16'(s1_dg_q) * 16'(s1_dg_q);
    s2_sb_q    <= 16'(s1_db_q) * 16'(s1_db_q);
    s2_entry_q <= s1_entry_q;
    s2_excl_q  <= s1_vbit_q & s1_mem_q;
    if (take) begin
      best_dist_q  <= cand_dist;
      best_entry_q <= s2_entry_q;
    end
  end

  assign status_o.last      = (entry_q == LAST_ENTRY);
  assign status_o.pipe_busy = s1_vld_q | s2_vld_q;

  assign result_o.found         = found_q;
  assign result_o.nearest_entry = found_q ? best_entry_q : 8'd0;

endmodule

>>> rtl/core/npem_ctrl.sv
module npem_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        kind_i,
  input  npem_pkg::status_t status_i,
  output npem_pkg::cmd_t    cmd_o,
  output logic              busy,
  output logic              done_o
);
  import npem_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign done_o = done_q;

  // commands to the datapath
  always_comb begin
    cmd_o      = '0;
    cmd_o.step = (state_q == ST_SCAN);
    if (accept) begin
      unique case (kind_i)
        KIND_FIND:  cmd_o.init  = 1'b1;
        KIND_MARK:  cmd_o.mark  = 1'b1;
        KIND_CLEAR: cmd_o.clear = 1'b1;
        default:    cmd_o       = '0;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && kind_i == KIND_FIND) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status_i.last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!status_i.pipe_busy) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for more than one cycle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result given while still busy");
  a_find_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_FIND) |=> busy) else $error("query accepted without scan");
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> !$past(status_i.pipe_busy)) else $error("result before pipe drained");
`endif

endmodule

>>> bench/palette_match_checker.sv
`timescale 1ns / 1ps

module palette_match_checker
  import npem_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    busy_i,
  input  item_t   item_i,
  input  logic    done_i,
  input  result_t result_i,
  input  logic    flush_i,
  output int      pending_o,
  output int      fail_count_o
);

  localparam int unsigned FAR_DISTANCE = 32'd1 << 30;

  logic [ENTRY_COUNT-1:0] excluded_entries;
  result_t                expected_matches[$];
  result_t                want;
  int                     error_count = 0;

  // one line per problem, counted
  task automatic report(input string msg);
    $display("error at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // channel value of a cube level index
  function automatic int unsigned level_value(input int unsigned idx);
    case (idx)
      0:       return 0;
      1:       return 95;
      2:       return 135;
      3:       return 175;
      4:       return 215;
      default: return 255;
    endcase
  endfunction

  function automatic int unsigned sq_gap(input int unsigned a, input int unsigned b);
    int unsigned d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  // scan entries 16 to 255 in order, lowest entry keeps a tie
  function automatic result_t nearest_unexcluded(input logic [23:0] color,
                                                 input logic [ENTRY_COUNT-1:0] mask);
    result_t     res;
    int unsigned best_dist;
    int unsigned cand_dist;
    int unsigned off;
    int unsigned cr, cg, cb;
    int unsigned tr, tg, tb;
    tr            = {24'd0, color[23:16]};
    tg            = {24'd0, color[15:8]};
    tb            = {24'd0, color[7:0]};
    best_dist     = FAR_DISTANCE;
    res           = '0;
    for (int e = FIRST_ENTRY; e < ENTRY_COUNT; e++) begin
      if (!mask[e]) begin
        if (e < GREY_START) begin
          off = e - FIRST_ENTRY;
          cr  = level_value((off / 36) % 6);
          cg  = level_value((off / 6) % 6);
          cb  = level_value(off % 6);
        end else begin
          cr = GREY_BASE + (e - GREY_START) * GREY_STEP;
          cg = cr;
          cb = cr;
        end
        cand_dist = sq_gap(tr, cr) + sq_gap(tg, cg) + sq_gap(tb, cb);
        if (cand_dist < best_dist) begin
          best_dist         = cand_dist;
          res.found         = 1'b1;
          res.nearest_entry = e[7:0];
        end
      end
    end
    return res;
  endfunction

  // results first, then the item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      excluded_entries = '0;
      expected_matches.delete();
      pending_o    <= 0;
      fail_count_o <= error_count;
    end else begin
      if (done_i) begin
        if (expected_matches.size() == 0) begin
          report($sformatf("result found=%0b entry=%0d with none expected",
                           result_i.found, result_i.nearest_entry));
        end else begin
          want = expected_matches.pop_front();
          if (result_i.found !== want.found) begin
            report($sformatf("found is %0b, predicted %0b", result_i.found, want.found));
          end
          if (result_i.nearest_entry !== want.nearest_entry) begin
            report($sformatf("nearest_entry is %0d, predicted %0d",
                             result_i.nearest_entry, want.nearest_entry));
          end
        end
      end
      if (start_i && !busy_i) begin
        case (item_i.kind)
          KIND_FIND: begin
            expected_matches.push_back(nearest_unexcluded(item_i.color, excluded_entries));
          end
          KIND_MARK: begin
            excluded_entries[item_i.entry_to_exclude] = 1'b1;
          end
          KIND_CLEAR: begin
            excluded_entries = '0;
          end
          default: ;
        endcase
      end
      if (flush_i && expected_matches.size() != 0) begin
        report($sformatf("%0d predicted results never came", expected_matches.size()));
        expected_matches.delete();
      end
      pending_o    <= expected_matches.size();
      fail_count_o <= error_count;
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import npem_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         TARGET_ITEMS = 1900;

  logic    clk_i   = 1'b0;
  logic    rst_ni  = 1'b0;
  logic    start   = 1'b0;
  logic    flush   = 1'b0;
  item_t   item_i  = '0;
  logic    busy;
  logic    done_o;
  result_t result_o;
  int      pending;
  int      fail_count;

  int      items_sent = 0;
  int      burst_left = 0;
  int      sweeps     = 0;

  nearest_palette_entry_match u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  palette_match_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item_i),
    .done_i       (done_o),
    .result_i     (result_o),
    .flush_i      (flush),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // 20 ns clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

  // bursts of items separated by random gaps
  task automatic send_item(input logic [1:0] kind, input logic [23:0] color,
                           input logic [7:0] entry);
    item_t it;
    int    gap;
    it.kind             = kind;
    it.color            = color;
    it.entry_to_exclude = entry;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                               : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // hold off until every predicted result is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] clip8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // one channel: random, near a cube level, halfway between levels, or an extreme
  function automatic logic [7:0] pick_channel();
    int lv;
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return clip8(int'(cube_level(3'($urandom_range(0, 5)))) +
                      int'($urandom_range(0, 6)) - 3);
      2: begin
        lv = $urandom_range(1, 4);
        return 8'((int'(cube_level(3'(lv))) + int'(cube_level(3'(lv + 1)))) / 2);
      end
      default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // channels of a palette entry, nudged a little
  function automatic logic [23:0] near_entry(input int e);
    int off, r, g, b, d;
    d = $urandom_range(0, 2);
    if (e < GREY_START) begin
      off = e - FIRST_ENTRY;
      r   = int'(cube_level(3'(off / 36)));
      g   = int'(cube_level(3'((off / 6) % 6)));
      b   = int'(cube_level(3'(off % 6)));
    end else begin
      r = GREY_BASE + (e - GREY_START) * GREY_STEP;
      g = r;
      b = r;
    end
    return {clip8(r + int'($urandom_range(0, 2 * d)) - d),
            clip8(g + int'($urandom_range(0, 2 * d)) - d),
            clip8(b + int'($urandom_range(0, 2 * d)) - d)};
  endfunction

  function automatic logic [23:0] rand_color();
    int g;
    case ($urandom_range(0, 3))
      0: return 24'($urandom() & 32'hFF_FFFF);
      1: return {pick_channel(), pick_channel(), pick_channel()};
      2: begin
        g = int'(GREY_BASE) + int'($urandom_range(0, 23)) * int'(GREY_STEP) +
            int'($urandom_range(0, 10)) - 5;
        return {clip8(g + int'($urandom_range(0, 2)) - 1), clip8(g),
                clip8(g + int'($urandom_range(0, 2)) - 1)};
      end
      default: return near_entry(int'($urandom_range(FIRST_ENTRY, LAST_ENTRY)));
    endcase
  endfunction

  function automatic logic [7:0] rand_entry();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(FIRST_ENTRY, LAST_ENTRY));
  endfunction

  // exclude every candidate but keep (none if keep is negative), query, mark an entry below 16, query again, then clear
  task automatic exclude_all_but(input int keep);
    int ofs, e;
    ofs = int'($urandom_range(0, 239));
    send_item(KIND_CLEAR, 24'($urandom()), 8'($urandom()));
    for (int i = 0; i < 240; i++) begin
      e = int'(FIRST_ENTRY) + (i + ofs) % 240;
      if (e != keep) send_item(KIND_MARK, 24'($urandom()), e[7:0]);
    end
    send_item(KIND_FIND, rand_color(), 8'($urandom()));
    send_item(KIND_MARK, 24'($urandom()), 8'($urandom_range(0, 15)));
    send_item(KIND_FIND, rand_color(), 8'($urandom()));
    send_item(KIND_CLEAR, 24'($urandom()), 8'($urandom()));
  endtask

  // exclude a run of neighbors, then query around the first of them
  task automatic exclude_cluster();
    int base, len;
    base = int'($urandom_range(FIRST_ENTRY, LAST_ENTRY));
    len  = int'($urandom_range(1, 8));
    for (int e = base; e < base + len && e <= LAST_ENTRY; e++) begin
      send_item(KIND_MARK, 24'($urandom()), e[7:0]);
    end
    repeat ($urandom_range(1, 3)) send_item(KIND_FIND, near_entry(base), 8'($urandom()));
  endtask

  initial begin
    int sel;

    // reset
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: corners, exact levels, ties, ignored kind, marks and clear
    send_item(KIND_FIND, 24'h000000, 8'h00);
    send_item(KIND_FIND, 24'hFFFFFF, 8'hFF);
    send_item(KIND_FIND, 24'h737373, 8'h00);
    send_item(KIND_FIND, 24'h739BC3, 8'h00);
    send_item(KIND_FIND, 24'h5F8700, 8'h00);
    send_item(KIND_FIND, 24'h080808, 8'h00);
    send_item(KIND_FIND, 24'hEEEEEE, 8'h00);
    send_item(KIND_FIND, 24'hFF0000, 8'h00);
    send_item(KIND_FIND, 24'h00FF00, 8'h00);
    send_item(KIND_FIND, 24'h0000FF, 8'h00);
    send_item(KIND_FIND, 24'h0D0D0D, 8'h00);
    send_item(KIND_UNUSED, 24'hFFFFFF, 8'h10);
    send_item(KIND_FIND, 24'h000000, 8'h00);
    send_item(KIND_MARK, 24'h000000, 8'd5);
    send_item(KIND_FIND, 24'h000000, 8'h00);
    send_item(KIND_MARK, 24'h000000, FIRST_ENTRY);
    send_item(KIND_MARK, 24'h000000, FIRST_ENTRY);
    send_item(KIND_FIND, 24'h000000, 8'h00);
    send_item(KIND_MARK, 24'h000000, 8'd231);
    send_item(KIND_MARK, 24'h000000, LAST_ENTRY);
    send_item(KIND_FIND, 24'hFFFFFF, 8'h00);
    send_item(KIND_FIND, 24'hEEEEEE, 8'h00);
    send_item(KIND_CLEAR, 24'h000000, 8'h00);
    send_item(KIND_FIND, 24'h000000, 8'h00);
    drain();

    // every candidate excluded
    exclude_all_but(-1);
    drain();

    // random mix
    while (items_sent < TARGET_ITEMS) begin
      sel = int'($urandom_range(0, 999));
      if (sel < 3 && sweeps < 2) begin
        sweeps++;
        exclude_all_but($urandom_range(0, 1) ? -1
                                             : int'($urandom_range(FIRST_ENTRY, LAST_ENTRY)));
      end else if (sel < 8) begin
        drain();
      end else if (sel < 60) begin
        exclude_cluster();
      end else if (sel < 600) begin
        send_item(KIND_FIND, rand_color(), 8'($urandom()));
      end else if (sel < 880) begin
        send_item(KIND_MARK, 24'($urandom()), rand_entry());
      end else if (sel < 910) begin
        send_item(KIND_CLEAR, 24'($urandom()), 8'($urandom()));
      end else if (sel < 940) begin
        send_item(KIND_UNUSED, 24'($urandom()), 8'($urandom()));
      end else begin
        send_item(KIND_FIND, 24'($urandom()), 8'($urandom()));
      end
    end

    // wait out the last results, then look for stray ones
    drain();
    repeat (300) @(posedge clk_i);
    flush <= 1'b1;
    @(posedge clk_i);
    flush <= 1'b0;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
